// File: hw/rtl/sgr_pkg.sv
// Shared types, constants and helper functions of the scaled text glyph rasterizer.
// Used by the controller, the datapath, the top level and the testbench; depends on nothing.
package sgr_pkg;

    // Screen, font and scale limits.
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;
    localparam int MAX_SCALE     = 8;
    localparam int FONT_DEPTH    = 512;
    localparam int FONT_AW       = $clog2(FONT_DEPTH);

    // Glyph geometry.
    localparam int GLYPH_COLS = 5;
    localparam int CELL_ROWS  = 8;
    localparam int ROW_W      = 48;

    // Cursor counters saturate at the all-ones value of CUR_W bits.
    localparam int CUR_W      = 13;
    localparam int CUR_SUM_W  = CUR_W + 1;
    localparam logic [CUR_W-1:0] CURSOR_CAP = {CUR_W{1'b1}};

    // Character codes.
    localparam logic [7:0] CODE_FIRST    = 8'd32;
    localparam logic [7:0] CODE_LAST     = 8'd126;
    localparam logic [7:0] CODE_QUESTION = 8'h3F;
    localparam logic [7:0] CODE_NL       = 8'h0A;
    localparam logic [7:0] CODE_CR       = 8'h0D;

    // Item commands.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // an input item is taken this cycle
        logic eval;       // apply text start, control codes and wrap
        logic place;      // bottom and right edge checks
        logic fetch;      // read one glyph column from the font store
        logic row_start;  // set up the row counters
        logic row_load;   // load the next row into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_render;  // the offered item is a render command
        logic eval_skip;  // the character gives no rows
        logic place_draw; // the cell fits and is drawn
        logic fetch_last; // the last glyph column is being read
        logic out_free;   // the output register can take a row
        logic row_last;   // the current row is the last of the cell
    } dp_status_t;

    // Column map: for each scale and mask bit, the glyph column it shows;
    // values of GLYPH_COLS and above mean the blank spacing column.
    typedef logic [MAX_SCALE-1:0][ROW_W-1:0][2:0] gx_map_t;

    function automatic gx_map_t build_gx_map();
        gx_map_t m;
        int gx;
        int cnt;
        m = '0;
        for (int s = 1; s <= MAX_SCALE; s++) begin
            gx  = 0;
            cnt = 0;
            for (int i = 0; i < ROW_W; i++) begin
                m[s-1][i] = 3'(gx);
                cnt++;
                if (cnt == s) begin
                    cnt = 0;
                    if (gx < 7) begin
                        gx++;
                    end
                end
            end
        end
        return m;
    endfunction

    localparam gx_map_t GX_MAP = build_gx_map();

    // Saturating cursor add.
    function automatic logic [CUR_W-1:0] sat_add(input logic [CUR_W-1:0] a,
                                                  input logic [6:0] b);
        logic [CUR_SUM_W-1:0] s;
        s = {1'b0, a} + CUR_SUM_W'(b);
        return (s > CUR_SUM_W'(CURSOR_CAP)) ? CURSOR_CAP : s[CUR_W-1:0];
    endfunction

    // True when a span of len starting at a passes the limit.
    function automatic logic passes(input logic [CUR_W-1:0] a,
                                    input logic [6:0] len,
                                    input int limit);
        logic [CUR_SUM_W-1:0] s;
        s = {1'b0, a} + CUR_SUM_W'(len);
        return s > CUR_SUM_W'(limit);
    endfunction

endpackage

// File: hw/rtl/sgr_if.sv
// Valid/ready channel interfaces for the glyph rasterizer's items and rows.
// Depends on nothing.
interface sgr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [8:0] font_addr;
    logic [7:0] font_byte;
    logic [7:0] char_code;
    logic       text_start;

    modport source (output valid, cmd, font_addr, font_byte, char_code, text_start,
                    input ready);
    modport sink (input valid, cmd, font_addr, font_byte, char_code, text_start,
                  output ready);
endinterface

interface sgr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  row_x;
    logic [8:0]  row_y;
    logic [5:0]  row_width;
    logic [47:0] row_mask;
    logic        cell_last;

    modport source (output valid, row_x, row_y, row_width, row_mask, cell_last,
                    input ready);
    modport sink (input valid, row_x, row_y, row_width, row_mask, cell_last,
                  output ready);
endinterface

// File: hw/rtl/sgr_ctrl.sv
// Controller state machine of the glyph rasterizer.
// Depends on sgr_pkg for the command and status structs.
module sgr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sgr_pkg::dp_status_t sts,
    output sgr_pkg::ctrl_cmd_t  ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_ROWS  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
                if (in_valid && sts.in_render)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = sts.eval_skip ? S_IDLE : S_PLACE;
            end
            S_PLACE:
            begin
                ctl.place  = 1'b1;
                state_next = sts.place_draw ? S_FETCH : S_IDLE;
            end
            S_FETCH:
            begin
                ctl.fetch = 1'b1;
                if (sts.fetch_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // The last column lands in the column registers this cycle.
                ctl.row_start = 1'b1;
                state_next    = S_ROWS;
            end
            S_ROWS:
            begin
                ctl.row_load = sts.out_free;
                if (sts.out_free && sts.row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/sgr_datapath.sv
// Datapath of the glyph rasterizer: configuration, font store, cursor and row output.
// Depends on sgr_pkg; driven by sgr_ctrl through the command struct.
module sgr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              cmd,
    input  logic [8:0]                        font_addr,
    input  logic [7:0]                        font_byte,
    input  logic [7:0]                        char_code,
    input  logic                              text_start,
    input  sgr_pkg::ctrl_cmd_t                ctl,
    output sgr_pkg::dp_status_t               sts,
    output logic                              row_valid,
    input  logic                              row_ready,
    output logic [7:0]                        row_x,
    output logic [8:0]                        row_y,
    output logic [5:0]                        row_width,
    output logic [47:0]                       row_mask,
    output logic                              cell_last
);

    // Configuration registers.
    logic [7:0] origin_x_reg;
    logic [8:0] origin_y_reg;
    logic [3:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sgr_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data[7:0];
                sgr_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data[8:0];
                sgr_pkg::CFG_SCALE:    scale_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Effective scale, cell width and cell height.
    logic [3:0] scale_eff;
    logic [5:0] cell_w;
    logic [6:0] cell_h;
    logic [2:0] scale_idx;

    always_comb
    begin
        priority if (scale_reg == 4'd0)
        begin
            scale_eff = 4'd1;
        end
        else if (scale_reg > 4'(sgr_pkg::MAX_SCALE))
        begin
            scale_eff = 4'(sgr_pkg::MAX_SCALE);
        end
        else
        begin
            scale_eff = scale_reg;
        end
    end

    assign cell_w    = {scale_eff, 2'b00} + {1'b0, scale_eff, 1'b0};
    assign cell_h    = {scale_eff, 3'b000};
    assign scale_idx = 3'(scale_eff - 4'd1);

    // Latched render item.
    logic       start_reg;
    logic [7:0] code_reg;
    logic [8:0] base_reg;
    logic [7:0] code_mapped;
    logic [6:0] glyph_idx;
    logic [8:0] glyph_base;

    assign code_mapped = (char_code < sgr_pkg::CODE_FIRST || char_code > sgr_pkg::CODE_LAST)
                         ? sgr_pkg::CODE_QUESTION : char_code;
    assign glyph_idx   = 7'(code_mapped - sgr_pkg::CODE_FIRST);
    assign glyph_base  = {glyph_idx, 2'b00} + 9'(glyph_idx);

    always_ff @(posedge clk)
    begin
        if (ctl.accept && cmd == sgr_pkg::CMD_RENDER)
        begin
            start_reg <= text_start;
            code_reg  <= char_code;
            base_reg  <= glyph_base;
        end
    end

    assign sts.in_render = (cmd == sgr_pkg::CMD_RENDER);

    // Font store with a registered read port.
    logic [7:0]                 font_mem [sgr_pkg::FONT_DEPTH];
    logic [7:0]                 rd_data_reg;
    logic                       font_we;
    logic [sgr_pkg::FONT_AW-1:0] wr_idx;
    logic [sgr_pkg::FONT_AW-1:0] rd_idx;
    logic [2:0]                 fetch_k_reg;
    logic                       cap_valid_reg;
    logic [2:0]                 cap_idx_reg;
    logic [4:0][7:0]            cols_reg;
    logic [8:0]                 rd_sum;

    assign font_we = ctl.accept && (cmd == sgr_pkg::CMD_LOAD)
                     && (32'(font_addr) < 32'(sgr_pkg::FONT_DEPTH));
    assign wr_idx  = sgr_pkg::FONT_AW'(font_addr);
    assign rd_sum  = base_reg + 9'(fetch_k_reg);
    assign rd_idx  = sgr_pkg::FONT_AW'(rd_sum);

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[wr_idx] <= font_byte;
        end
        if (ctl.fetch)
        begin
            rd_data_reg <= font_mem[rd_idx];
        end
        if (cap_valid_reg)
        begin
            cols_reg[cap_idx_reg] <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_k_reg   <= '0;
            cap_valid_reg <= 1'b0;
            cap_idx_reg   <= '0;
        end
        else
        begin
            cap_valid_reg <= ctl.fetch;
            cap_idx_reg   <= fetch_k_reg;
            if (ctl.place)
            begin
                fetch_k_reg <= '0;
            end
            else if (ctl.fetch)
            begin
                fetch_k_reg <= fetch_k_reg + 3'd1;
            end
        end
    end

    assign sts.fetch_last = (fetch_k_reg == 3'(sgr_pkg::GLYPH_COLS - 1));

    // Cursor and drop state.
    logic [sgr_pkg::CUR_W-1:0] col_reg;
    logic [sgr_pkg::CUR_W-1:0] col_next;
    logic [sgr_pkg::CUR_W-1:0] row_reg;
    logic [sgr_pkg::CUR_W-1:0] row_next;
    logic                      done_reg;
    logic                      done_next;
    logic [sgr_pkg::CUR_W-1:0] col_a;
    logic [sgr_pkg::CUR_W-1:0] row_a;
    logic                      done_a;
    logic                      is_cr;
    logic                      is_nl;
    logic                      row_over;
    logic                      col_over;
    logic                      row_last;

    assign col_a    = start_reg ? sgr_pkg::CUR_W'(origin_x_reg) : col_reg;
    assign row_a    = start_reg ? sgr_pkg::CUR_W'(origin_y_reg) : row_reg;
    assign done_a   = start_reg ? 1'b0 : done_reg;
    assign is_cr    = (code_reg == sgr_pkg::CODE_CR);
    assign is_nl    = (code_reg == sgr_pkg::CODE_NL);
    assign row_over = sgr_pkg::passes(row_reg, cell_h, sgr_pkg::SCREEN_HEIGHT);
    assign col_over = sgr_pkg::passes(col_reg, 7'(cell_w), sgr_pkg::SCREEN_WIDTH);

    assign sts.eval_skip  = done_a || is_cr || is_nl;
    assign sts.place_draw = !row_over && !col_over;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        priority if (ctl.eval)
        begin
            col_next  = col_a;
            row_next  = row_a;
            done_next = done_a;
            if (!done_a && !is_cr)
            begin
                // A newline, or a cell that would pass the right edge, starts a new line.
                if (is_nl || sgr_pkg::passes(col_a, 7'(cell_w), sgr_pkg::SCREEN_WIDTH))
                begin
                    col_next = sgr_pkg::CUR_W'(origin_x_reg);
                    row_next = sgr_pkg::sat_add(row_a, cell_h);
                end
            end
        end
        else if (ctl.place)
        begin
            if (row_over)
            begin
                done_next = 1'b1;
            end
            else if (col_over)
            begin
                col_next = sgr_pkg::sat_add(col_reg, 7'(cell_w));
            end
        end
        else if (ctl.row_load && row_last)
        begin
            col_next = sgr_pkg::sat_add(col_reg, 7'(cell_w));
        end
        else
        begin
            col_next = col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
        end
    end

    // Row counters: sub-row within a glyph row, glyph row, and screen row.
    logic [2:0] sy_reg;
    logic [2:0] gy_reg;
    logic [8:0] y_reg;

    assign row_last     = (gy_reg == 3'(sgr_pkg::CELL_ROWS - 1)) && (sy_reg == scale_idx);
    assign sts.row_last = row_last;

    always_ff @(posedge clk)
    begin
        if (ctl.row_start)
        begin
            sy_reg <= '0;
            gy_reg <= '0;
            y_reg  <= row_reg[8:0];
        end
        else if (ctl.row_load)
        begin
            y_reg <= y_reg + 9'd1;
            if (sy_reg == scale_idx)
            begin
                sy_reg <= '0;
                gy_reg <= gy_reg + 3'd1;
            end
            else
            begin
                sy_reg <= sy_reg + 3'd1;
            end
        end
    end

    // Horizontal expansion of one glyph row through the column map.
    logic [7:0]  row_bits;
    logic [47:0] mask;
    logic [2:0]  gx;

    always_comb
    begin
        row_bits = '0;
        for (int k = 0; k < sgr_pkg::GLYPH_COLS; k++)
        begin
            // The bottom row of the cell is spacing.
            row_bits[k] = cols_reg[k][gy_reg] && (gy_reg != 3'(sgr_pkg::CELL_ROWS - 1));
        end
    end

    always_comb
    begin
        mask = '0;
        gx   = '0;
        for (int i = 0; i < sgr_pkg::ROW_W; i++)
        begin
            gx      = sgr_pkg::GX_MAP[scale_idx][i];
            mask[i] = row_bits[gx];
        end
    end

    // Output register.
    logic row_valid_reg;

    assign sts.out_free = !row_valid_reg || row_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else if (ctl.row_load)
        begin
            row_valid_reg <= 1'b1;
        end
        else if (row_ready)
        begin
            row_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.row_load)
        begin
            row_x     <= col_reg[7:0];
            row_y     <= y_reg;
            row_width <= cell_w;
            row_mask  <= mask;
            cell_last <= row_last;
        end
    end

    assign row_valid = row_valid_reg;

endmodule

// File: hw/rtl/scaled_text_glyph_rasterizer.sv
// A font byte load is written to the font store when it is accepted. A drawn character goes
// through accept, cursor update, edge checks, 5 font store reads and a wait for the last read
// to land, then one row per cycle from the output register while the sink is ready. Skipped
// characters (control codes, dropped text, cells that do not fit) end before any font read.
// Reset (rst_n, asynchronous, active low) clears the cursor, the drop flag and the handshakes,
// and sets origin to (0, 0) and scale to 1; the font store holds garbage until it is loaded.
module scaled_text_glyph_rasterizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgr_pkg::CFG_DATA_W-1:0] cfg_data,
    sgr_in_if.sink                         glyph_cmd,
    sgr_out_if.source                      glyph_row
);

    // The controller sequences each item; the datapath holds all other state.
    sgr_pkg::ctrl_cmd_t  ctl;
    sgr_pkg::dp_status_t sts;
    logic                in_ready;

    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (glyph_cmd.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The input is taken only when the controller is idle, so every item is handled in full
    // before the next one; the last rows of a character may still wait in the output register.
    assign glyph_cmd.ready = in_ready;

    sgr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (glyph_cmd.cmd),
        .font_addr  (glyph_cmd.font_addr),
        .font_byte  (glyph_cmd.font_byte),
        .char_code  (glyph_cmd.char_code),
        .text_start (glyph_cmd.text_start),
        .ctl        (ctl),
        .sts        (sts),
        .row_valid  (glyph_row.valid),
        .row_ready  (glyph_row.ready),
        .row_x      (glyph_row.row_x),
        .row_y      (glyph_row.row_y),
        .row_width  (glyph_row.row_width),
        .row_mask   (glyph_row.row_mask),
        .cell_last  (glyph_row.cell_last)
    );

endmodule

// File: hw/rtl/sgr_checker.sv
// Port-level checks of the glyph rasterizer's row output, bound to the top level.
// Depends on the top level's port names only.
module sgr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        row_valid,
    input logic        row_ready,
    input logic [5:0]  row_width,
    input logic [47:0] row_mask,
    input logic        cell_last,
    input logic [8:0]  row_y
);

    // A stalled row holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready |=> row_valid && $stable(row_mask) && $stable(row_y)
        && $stable(cell_last) && $stable(row_width))
        else $error("row changed while stalled");

    // The cell width is six pixels per unit of scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row_width == 6'd6 || row_width == 6'd12 || row_width == 6'd18
        || row_width == 6'd24 || row_width == 6'd30 || row_width == 6'd36
        || row_width == 6'd42 || row_width == 6'd48))
        else $error("illegal row width");

    // No pixel is set beyond the cell width.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row_mask >> row_width) == 48'd0)
        else $error("mask bit beyond row width");

    // Reset empties the output register.
    assert property (@(posedge clk) !rst_n |=> !row_valid)
        else $error("row valid during reset");

endmodule

bind scaled_text_glyph_rasterizer sgr_checker u_sgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (glyph_row.valid),
    .row_ready (glyph_row.ready),
    .row_width (glyph_row.row_width),
    .row_mask  (glyph_row.row_mask),
    .cell_last (glyph_row.cell_last),
    .row_y     (glyph_row.row_y)
);

// File: tb/tb_scaled_text_glyph_rasterizer.sv
`timescale 1ns / 1ps
// Self-checking testbench of the scaled text glyph rasterizer: predicts every pixel row of
// every drawn character and checks the row stream. Depends on sgr_pkg, sgr_if and the RTL.
module tb_scaled_text_glyph_rasterizer;

    // Cell geometry that the package does not name.
    localparam int CELL_W  = 6;
    localparam int GLYPH_H = 7;

    // Register index that no register answers to; a write to it must change nothing.
    localparam logic [sgr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Glyphs whose font columns are loaded; the text only ever draws these. Codes outside
    // the printable range are drawn as the question mark, which is one of them.
    localparam int NUM_GLYPHS = 6;
    localparam logic [NUM_GLYPHS-1:0][7:0] GLYPH_SET =
        {8'h7E, 8'h5A, 8'h48, 8'h41, 8'h3F, 8'h20};

    // Timing of the run. The longest correct gap between two accepted items is the long
    // receiver hold, so the watchdog limit is several times that.
    localparam int IDLE_MAX      = 6;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct {
        logic       cmd;
        logic [8:0] font_addr;
        logic [7:0] font_byte;
        logic [7:0] char_code;
        logic       text_start;
    } glyph_cmd_t;

    typedef struct {
        logic [7:0]  x;
        logic [8:0]  y;
        logic [5:0]  width;
        logic [47:0] mask;
        logic        last;
    } pixel_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sgr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sgr_pkg::CFG_DATA_W-1:0] cfg_data;

    sgr_in_if  cmd_ch ();
    sgr_out_if row_ch ();

    scaled_text_glyph_rasterizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .glyph_cmd (cmd_ch),
        .glyph_row (row_ch)
    );

    // Items still to be offered, and the rows that the accepted items must still produce.
    glyph_cmd_t pending_cmds [$];
    pixel_row_t rows_due [$];

    // The predictor's own copy of the block's state and registers.
    logic [7:0]  font_copy [sgr_pkg::FONT_DEPTH];
    int unsigned cur_col;
    int unsigned cur_row;
    bit          text_dropped;
    logic [7:0]  org_x;
    logic [8:0]  org_y;
    logic [3:0]  scale_reg;

    // Handshake bookkeeping. Besides the initial block, each counter has exactly one writer.
    int cmds_offered;
    int cmds_taken;
    int cmds_acked;
    int rows_taken;
    int rows_acked;
    int stall_reqs;
    int stalls_served;
    int send_wait;
    int recv_wait;
    int hold_left;
    bit send_fast;
    bit recv_fast;
    int quiet_cycles;
    int mismatches;

    glyph_cmd_t cmd_seen;
    glyph_cmd_t cmd_next;
    pixel_row_t row_seen;
    pixel_row_t row_want;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One line per mismatch; every mismatch is counted.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned cap_add(input int unsigned a, input int unsigned b);
        int unsigned sum;
        sum = a + b;
        return (sum > 32'(sgr_pkg::CURSOR_CAP)) ? 32'(sgr_pkg::CURSOR_CAP) : sum;
    endfunction

    // Register write as seen by the predictor; the block masks the data to each register.
    function automatic void model_register(input logic [sgr_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [sgr_pkg::CFG_DATA_W-1:0] data);
        if (idx == sgr_pkg::CFG_ORIGIN_X)
        begin
            org_x = data[7:0];
        end
        else if (idx == sgr_pkg::CFG_ORIGIN_Y)
        begin
            org_y = data[8:0];
        end
        else if (idx == sgr_pkg::CFG_SCALE)
        begin
            scale_reg = data[3:0];
        end
    endfunction

    // Works out the rows that one accepted item causes and queues them in order. Font loads
    // only update the font copy. Text start moves the cursor to the origin and clears the
    // drop flag before anything else. Dropped text swallows every character, control codes
    // too. A cell too wide to fit even after a wrap draws nothing but still moves the cursor.
    task automatic rasterize_item(input glyph_cmd_t it);
        int unsigned s;
        int unsigned cw;
        int unsigned ch;
        int unsigned code;
        int unsigned base;
        int unsigned gy;
        int unsigned gx;
        int unsigned r;
        int unsigned i;
        logic [7:0]  cols [sgr_pkg::GLYPH_COLS];
        pixel_row_t  row;

        if (it.cmd == sgr_pkg::CMD_LOAD)
        begin
            if (it.font_addr < sgr_pkg::FONT_DEPTH)
            begin
                font_copy[it.font_addr] = it.font_byte;
            end
            return;
        end
        if (it.text_start)
        begin
            cur_col      = 32'(org_x);
            cur_row      = 32'(org_y);
            text_dropped = 1'b0;
        end
        if (text_dropped)
        begin
            return;
        end

        s = (scale_reg == 4'd0) ? 32'd1 : 32'(scale_reg);
        if (s > sgr_pkg::MAX_SCALE)
        begin
            s = sgr_pkg::MAX_SCALE;
        end
        cw   = CELL_W * s;
        ch   = sgr_pkg::CELL_ROWS * s;
        code = 32'(it.char_code);

        if (code == 32'(sgr_pkg::CODE_CR))
        begin
            return;
        end
        if (code == 32'(sgr_pkg::CODE_NL))
        begin
            cur_col = 32'(org_x);
            cur_row = cap_add(cur_row, ch);
            return;
        end
        if (code < 32'(sgr_pkg::CODE_FIRST) || code > 32'(sgr_pkg::CODE_LAST))
        begin
            code = 32'(sgr_pkg::CODE_QUESTION);
        end

        // Wrap first, then the bottom edge ends the text, then the right edge may still
        // refuse the cell when the origin itself leaves no room.
        if (cur_col + cw > sgr_pkg::SCREEN_WIDTH)
        begin
            cur_col = 32'(org_x);
            cur_row = cap_add(cur_row, ch);
        end
        if (cur_row + ch > sgr_pkg::SCREEN_HEIGHT)
        begin
            text_dropped = 1'b1;
            return;
        end
        if (cur_col + cw > sgr_pkg::SCREEN_WIDTH)
        begin
            cur_col = cap_add(cur_col, cw);
            return;
        end

        base = (code - 32'(sgr_pkg::CODE_FIRST)) * sgr_pkg::GLYPH_COLS;
        for (i = 0; i < sgr_pkg::GLYPH_COLS; i++)
        begin
            cols[3'(i)] = font_copy[9'(base + i)];
        end

        // Each glyph pixel becomes an s by s block; the sixth column and the eighth row of
        // the cell are blank spacing, and bit 7 of a font byte is never shown.
        for (r = 0; r < ch; r++)
        begin
            gy       = r / s;
            row.mask = '0;
            if (gy < GLYPH_H)
            begin
                for (i = 0; i < cw; i++)
                begin
                    gx = i / s;
                    if (gx < sgr_pkg::GLYPH_COLS && cols[3'(gx)][3'(gy)])
                    begin
                        row.mask[6'(i)] = 1'b1;
                    end
                end
            end
            row.x     = cur_col[7:0];
            row.y     = 9'(cur_row + r);
            row.width = 6'(cw);
            row.last  = (r + 1 == ch);
            rows_due.push_back(row);
        end
        cur_col = cap_add(cur_col, cw);
    endtask

    function automatic void queue_char(input logic [7:0] code, input logic start);
        glyph_cmd_t it;
        it.cmd        = sgr_pkg::CMD_RENDER;
        it.font_addr  = 9'($urandom);
        it.font_byte  = 8'($urandom);
        it.char_code  = code;
        it.text_start = start;
        pending_cmds.push_back(it);
    endfunction

    function automatic void queue_load(input logic [8:0] addr, input logic [7:0] data,
                                       input logic start);
        glyph_cmd_t it;
        it.cmd        = sgr_pkg::CMD_LOAD;
        it.font_addr  = addr;
        it.font_byte  = data;
        it.char_code  = 8'($urandom);
        it.text_start = start;
        pending_cmds.push_back(it);
    endfunction

    // Mostly printable text from the loaded glyphs, with font reloads, control codes, codes
    // outside the printable range and the odd restart mixed in.
    function automatic void queue_random_text(input bit first);
        int   pick;
        int   k;
        logic start;
        pick  = $urandom_range(0, 99);
        k     = $urandom_range(0, NUM_GLYPHS - 1);
        start = first ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
        if (pick < 8)
        begin
            queue_load(9'($urandom_range(0, sgr_pkg::FONT_DEPTH - 1)), 8'($urandom),
                       1'($urandom_range(0, 1)));
        end
        else if (pick < 14)
        begin
            queue_char(sgr_pkg::CODE_NL, start);
        end
        else if (pick < 18)
        begin
            queue_char(sgr_pkg::CODE_CR, start);
        end
        else if (pick < 30)
        begin
            queue_char(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                   : 8'($urandom_range(127, 255)), start);
        end
        else
        begin
            queue_char(GLYPH_SET[k], start);
        end
    endfunction

    // Waits until every item has gone in and every row has come out, then lets the block
    // finish any character that produces no rows before the registers may change.
    task automatic settle();
        while (pending_cmds.size() != 0 || cmds_offered != cmds_taken || rows_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write, only ever called while the block is idle.
    task automatic write_reg(input logic [sgr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgr_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        model_register(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sender: offers the next queued item after a random gap. The valid line stays high
    // from one item to the next when the gap is zero.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmds_taken != cmds_acked)
            begin
                cmds_acked = cmds_taken;
                if ($urandom_range(0, 15) == 0)
                begin
                    send_fast = !send_fast;
                end
                send_wait = send_fast ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (cmds_offered == cmds_taken)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd_next = pending_cmds.pop_front();
                    cmds_offered++;
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.cmd        <= cmd_next.cmd;
                    cmd_ch.font_addr  <= cmd_next.font_addr;
                    cmd_ch.font_byte  <= cmd_next.font_byte;
                    cmd_ch.char_code  <= cmd_next.char_code;
                    cmd_ch.text_start <= cmd_next.text_start;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls a random number of cycles before each row, and serves requests for
    // a long hold-off that lets the block fill up and push back on the sender.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_reqs != stalls_served)
            begin
                stalls_served++;
                hold_left = LONG_HOLD;
            end
            if (rows_taken != rows_acked)
            begin
                rows_acked = rows_taken;
                if ($urandom_range(0, 15) == 0)
                begin
                    recv_fast = !recv_fast;
                end
                recv_wait = recv_fast ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                row_ch.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                row_ch.ready <= 1'b0;
            end
            else
            begin
                row_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: at each rising edge, an accepted item feeds the predictor and an accepted
    // row is checked field by field against the oldest predicted row. A row can never
    // come out at the edge that takes in the item causing it, so the order is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_seen.cmd        = cmd_ch.cmd;
                cmd_seen.font_addr  = cmd_ch.font_addr;
                cmd_seen.font_byte  = cmd_ch.font_byte;
                cmd_seen.char_code  = cmd_ch.char_code;
                cmd_seen.text_start = cmd_ch.text_start;
                rasterize_item(cmd_seen);
                cmds_taken++;
                quiet_cycles = 0;
            end
            if (row_ch.valid && row_ch.ready)
            begin
                row_seen.x     = row_ch.row_x;
                row_seen.y     = row_ch.row_y;
                row_seen.width = row_ch.row_width;
                row_seen.mask  = row_ch.row_mask;
                row_seen.last  = row_ch.cell_last;
                if (rows_due.size() == 0)
                begin
                    report_mismatch("row with none expected (row_y)", 64'(row_seen.y), 64'd0);
                end
                else
                begin
                    row_want = rows_due.pop_front();
                    if (row_seen.x !== row_want.x)
                    begin
                        report_mismatch("row_x", 64'(row_seen.x), 64'(row_want.x));
                    end
                    if (row_seen.y !== row_want.y)
                    begin
                        report_mismatch("row_y", 64'(row_seen.y), 64'(row_want.y));
                    end
                    if (row_seen.width !== row_want.width)
                    begin
                        report_mismatch("row_width", 64'(row_seen.width), 64'(row_want.width));
                    end
                    if (row_seen.mask !== row_want.mask)
                    begin
                        report_mismatch("row_mask", 64'(row_seen.mask), 64'(row_want.mask));
                    end
                    if (row_seen.last !== row_want.last)
                    begin
                        report_mismatch("cell_last", 64'(row_seen.last), 64'(row_want.last));
                    end
                end
                rows_taken++;
                quiet_cycles = 0;
            end
        end
    end

    // Watchdog: ends a run in which nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n && quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase_scale [7];
        int items_left;

        phase_scale = '{1, 2, 0, 3, 8, 15, 2};

        // All inputs known from time zero; the predictor starts from the reset state.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = sgr_pkg::CMD_LOAD;
        cmd_ch.font_addr  = '0;
        cmd_ch.font_byte  = '0;
        cmd_ch.char_code  = '0;
        cmd_ch.text_start = 1'b0;
        row_ch.ready      = 1'b0;
        cur_col           = 0;
        cur_row           = 0;
        text_dropped      = 1'b0;
        org_x             = '0;
        org_y             = '0;
        scale_reg         = 4'd1;
        cmds_offered      = 0;
        cmds_taken        = 0;
        cmds_acked        = 0;
        rows_taken        = 0;
        rows_acked        = 0;
        stall_reqs        = 0;
        stalls_served     = 0;
        send_wait         = 0;
        recv_wait         = 0;
        hold_left         = 0;
        send_fast         = 1'b0;
        recv_fast         = 1'b0;
        quiet_cycles      = 0;
        mismatches        = 0;
        for (int a = 0; a < sgr_pkg::FONT_DEPTH; a++)
        begin
            font_copy[a] = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The font store holds garbage after reset, so the columns of every glyph that the
        // text can draw are loaded first. Text start on a font load must have no effect.
        for (int g = 0; g < NUM_GLYPHS; g++)
        begin
            for (int c = 0; c < sgr_pkg::GLYPH_COLS; c++)
            begin
                queue_load(9'((int'(GLYPH_SET[g]) - int'(sgr_pkg::CODE_FIRST))
                              * sgr_pkg::GLYPH_COLS + c),
                           8'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        // Reset registers: origin (0, 0), scale 1. The printable range edges, codes just
        // outside it and at the byte extremes (drawn as a question mark), the two control
        // codes, and a font load between characters that must not restart the text.
        queue_char(8'h20, 1'b1);
        queue_char(8'h7E, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h7F, 1'b0);
        queue_char(8'h1F, 1'b0);
        queue_char(sgr_pkg::CODE_CR, 1'b0);
        queue_char(sgr_pkg::CODE_NL, 1'b0);
        queue_char(8'h41, 1'b0);
        queue_load(9'h1A0, 8'($urandom), 1'b1);
        queue_char(8'h48, 1'b0);
        settle();

        // Largest scale with an origin that leaves no room: the cell never fits, so nothing
        // is drawn, yet the cursor keeps moving.
        write_reg(sgr_pkg::CFG_ORIGIN_X, 9'd200);
        write_reg(sgr_pkg::CFG_SCALE, 9'd8);
        queue_char(8'h48, 1'b1);
        queue_char(8'h41, 1'b0);
        settle();

        // Origin that just fits: five lines of one cell each fill the screen to the bottom
        // row, the sixth cell passes it and ends the text, and everything after is dropped
        // until the next text start.
        write_reg(sgr_pkg::CFG_ORIGIN_X, 9'd192);
        queue_char(8'h48, 1'b1);
        queue_char(8'h41, 1'b0);
        queue_char(8'h5A, 1'b0);
        queue_char(8'h7E, 1'b0);
        queue_char(8'h20, 1'b0);
        queue_char(8'h3F, 1'b0);
        queue_char(sgr_pkg::CODE_NL, 1'b0);
        queue_char(sgr_pkg::CODE_CR, 1'b0);
        queue_char(8'h48, 1'b0);
        queue_char(8'h41, 1'b1);
        settle();

        // Origin at the far corner; the data's top bit is cut off for origin_x. Scale 0
        // counts as 1. A write to the unused index must change nothing.
        write_reg(sgr_pkg::CFG_ORIGIN_X, 9'h1EF);
        write_reg(sgr_pkg::CFG_ORIGIN_Y, 9'd319);
        write_reg(sgr_pkg::CFG_SCALE, 9'd0);
        write_reg(CFG_UNUSED, 9'($urandom));
        queue_char(8'h5A, 1'b1);
        queue_char(8'h41, 1'b0);
        settle();

        // Random phases, each with its own register setting. The block is idle at every
        // setting change. In the scale 8 phase the receiver holds off for a long stretch
        // while the sender keeps offering; in another the sender pauses halfway until all
        // rows are out.
        for (int p = 0; p < 7; p++)
        begin
            if (phase_scale[p] == 8)
            begin
                write_reg(sgr_pkg::CFG_ORIGIN_X, 9'd0);
                write_reg(sgr_pkg::CFG_ORIGIN_Y, 9'd0);
            end
            else
            begin
                write_reg(sgr_pkg::CFG_ORIGIN_X, 9'($urandom_range(0, 160)));
                write_reg(sgr_pkg::CFG_ORIGIN_Y, 9'($urandom_range(0, 200)));
            end
            write_reg(sgr_pkg::CFG_SCALE, 9'(phase_scale[p]));
            if (phase_scale[p] == 8)
            begin
                stall_reqs++;
            end
            items_left = 8;
            for (int i = 0; i < items_left; i++)
            begin
                if (p == 2 && i == 4)
                begin
                    settle();
                end
                queue_random_text(i == 0);
            end
            settle();
        end

        // Newlines carry the cursor row past the range of a 9-bit screen row instead of
        // wrapping it back onto the screen, so the character after them is dropped; a new
        // text draws again.
        write_reg(sgr_pkg::CFG_ORIGIN_X, 9'd0);
        write_reg(sgr_pkg::CFG_ORIGIN_Y, 9'd0);
        write_reg(sgr_pkg::CFG_SCALE, 9'd8);
        queue_char(8'h41, 1'b1);
        for (int i = 0; i < 8; i++)
        begin
            queue_char(sgr_pkg::CODE_NL, 1'b0);
        end
        queue_char(8'h48, 1'b0);
        queue_char(8'h5A, 1'b1);
        settle();

        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: scaled_text_glyph_rasterizer.f
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_if.sv
hw/rtl/sgr_ctrl.sv
hw/rtl/sgr_datapath.sv
hw/rtl/scaled_text_glyph_rasterizer.sv
hw/rtl/sgr_checker.sv
tb/tb_scaled_text_glyph_rasterizer.sv
